/* sv/rcsn_pkg.sv */
// rcsn_pkg: shared widths, fixed-point constants and register codes of the stick normalizer
// used by rc_stick_normalizer_unit and rcsn_checker; depends on nothing

package rcsn_pkg;

  // raw channel and fixed-point format
  localparam int RAW_W      = 11;
  localparam int FRAC_W     = 14;
  localparam int Q_ONE      = 16384;

  // trim registers
  localparam int TRIM_W     = 13;
  localparam int TRIM_LIMIT = 3277;
  localparam int CFG_IDX_W  = 2;

  // result fields
  localparam int CMD_W      = 16;
  localparam int THR_W      = 15;
  // magnitude of a trimmed stick value, up to 1.0 plus the trim limit
  localparam int DB_MAG_W   = 15;

  // stream payload layout
  localparam int IN_FIELDS     = 5;
  localparam int IN_TDATA_W    = ((IN_FIELDS * RAW_W + 7) / 8) * 8;
  localparam int OUT_ROLL_LSB  = 0;
  localparam int OUT_PITCH_LSB = OUT_ROLL_LSB + CMD_W;
  localparam int OUT_YAW_LSB   = OUT_PITCH_LSB + CMD_W;
  localparam int OUT_THR_LSB   = OUT_YAW_LSB + CMD_W;
  localparam int OUT_MODE_LSB  = OUT_THR_LSB + THR_W;
  localparam int OUT_STAB_BIT  = OUT_MODE_LSB + CMD_W;
  localparam int OUT_TDATA_W   = ((OUT_STAB_BIT + 1 + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM_ROLL     = 2'd0,
    REG_TRIM_PITCH    = 2'd1,
    REG_TRIM_YAW      = 2'd2,
    REG_TRIM_THROTTLE = 2'd3
  } cfg_reg_e;

endpackage

/* sv/rcsn_cdiv.sv */
// rcsn_cdiv: rounding-free floor division of an unsigned value by an elaboration-time constant
// two register stages: reciprocal multiply, then back-multiply; correction on the output

module rcsn_cdiv #(
  parameter int NUM_W = 25,
  parameter int DEN   = 819
) (
  input  logic             clk_i,
  input  logic [1:0]       en_i,   // per-stage load enables
  input  logic [NUM_W-1:0] num_i,
  output logic [NUM_W-1:0] quo_o
);

  localparam int MulW = NUM_W + 1;
  localparam logic [MulW-1:0]  Recip  = MulW'((longint'(1) << NUM_W) / DEN);
  localparam logic [NUM_W-1:0] DenVal = NUM_W'(DEN);

  logic [NUM_W-1:0]        num_a_q;
  logic [NUM_W+MulW-1:0]   prod_q;
  logic [NUM_W-1:0]        num_b_q;
  logic [NUM_W-1:0]        q0_d, q0_q;
  logic [NUM_W-1:0]        qd_d, qd_q;
  logic [2*NUM_W-1:0]      qd_full;
  logic [NUM_W-1:0]        rem;

  // estimate is exact or one low because num stays below 2**NUM_W
  assign q0_d    = prod_q[2*NUM_W-1:NUM_W];
  assign qd_full = q0_d * DenVal;
  assign qd_d    = qd_full[NUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_a_q <= num_i;
      prod_q  <= num_i * Recip;
    end
    if (en_i[1]) begin
      num_b_q <= num_a_q;
      q0_q    <= q0_d;
      qd_q    <= qd_d;
    end
  end

  assign rem   = num_b_q - qd_q;
  assign quo_o = q0_q + NUM_W'(rem >= DenVal);

endmodule

/* sv/rc_stick_normalizer_unit.sv */
// rc_stick_normalizer_unit: top level of the receiver stick normalizer
// depends on rcsn_pkg and rcsn_cdiv

// Takes one frame of five raw 11-bit receiver channels per transfer and returns one
// frame of normalized Q2.14 commands. Roll, pitch, yaw and mode are centered on
// RAW_CENTER, scaled so RAW_MAX reads +1.0 and clamped to +/-1.0; roll, pitch and yaw
// then get their trim and a deadband that zeroes values up to DEADBAND_Q14 and rescales
// the rest to full scale, with no clamp after the trim. Throttle maps RAW_MIN..RAW_MAX
// to 0..1.0, gets its trim and is clamped to 0..1.0. The stabilized bit is set when
// the mode value is above zero. All divisions round to nearest, ties away from zero.
// The block takes one frame every clock cycle while the output is not stalled; a frame
// passes through two constant dividers in series (reciprocal multiply, back-multiply
// and correct), each with two register stages, the first of which also serves as
// the input register, plus the trim and output stages. Trims saturate to
// +/-0.2 on write and should be written only while no frame is in flight.

module rc_stick_normalizer_unit #(
  parameter int RAW_CENTER   = 992,
  parameter int RAW_MIN      = 172,
  parameter int RAW_MAX      = 1811,
  parameter int DEADBAND_Q14 = 819
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // raw frame in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // roll_raw, pitch_raw, yaw_raw, throttle_raw, mode_raw_in (11 bits each), zero pad
  input  logic [rcsn_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // normalized frame out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // roll_cmd, pitch_cmd, yaw_cmd (16 each), throttle_cmd (15), mode_cmd (16),
  // stabilized (1)
  output logic [rcsn_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // trim register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rcsn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcsn_pkg::TRIM_W-1:0]        cfg_data_i
);

  localparam int NStages   = 6;
  localparam int NSticks   = 4;   // roll, pitch, yaw, mode
  localparam int NTrimmed  = 3;   // roll, pitch, yaw
  localparam int RawW      = rcsn_pkg::RAW_W;
  localparam int FracW     = rcsn_pkg::FRAC_W;
  localparam int CmdW      = rcsn_pkg::CMD_W;
  localparam int ThrW      = rcsn_pkg::THR_W;
  localparam int TrimW     = rcsn_pkg::TRIM_W;
  localparam int SumW      = CmdW + 1;
  localparam int StickNumW = RawW + FracW;
  localparam int DbNumW    = rcsn_pkg::DB_MAG_W + FracW;

  // degenerate spans fall back to a divisor of one
  localparam int DenStick = (RAW_MAX - RAW_CENTER < 1) ? 1 : RAW_MAX - RAW_CENTER;
  localparam int DenThr   = (RAW_MAX - RAW_MIN < 1) ? 1 : RAW_MAX - RAW_MIN;
  localparam int DenDb    = (rcsn_pkg::Q_ONE - DEADBAND_Q14 < 1) ? 1
                          : rcsn_pkg::Q_ONE - DEADBAND_Q14;
  localparam int HalfStick = DenStick / 2;
  localparam int HalfThr   = DenThr / 2;
  localparam int HalfDb    = DenDb / 2;

  localparam logic [ThrW-1:0]          QOneU   = ThrW'(rcsn_pkg::Q_ONE);
  localparam logic signed [SumW-1:0]   QOneS   = SumW'(rcsn_pkg::Q_ONE);
  localparam logic signed [TrimW-1:0]  TrimMax = TrimW'(rcsn_pkg::TRIM_LIMIT);
  localparam logic [CmdW-1:0]          DbVal   = CmdW'(DEADBAND_Q14);

  // ---------------------------------------------------------------------------
  // trim registers, saturated on write
  // ---------------------------------------------------------------------------
  logic signed [TrimW-1:0] trim_q [4];
  logic signed [TrimW-1:0] cfg_sat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_sat = $signed(cfg_data_i);
    if (cfg_sat > TrimMax) begin
      cfg_sat = TrimMax;
    end else if (cfg_sat < -TrimMax) begin
      cfg_sat = -TrimMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        trim_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rcsn_pkg::cfg_reg_e'(cfg_index_i))
        rcsn_pkg::REG_TRIM_ROLL:     trim_q[0] <= cfg_sat;
        rcsn_pkg::REG_TRIM_PITCH:    trim_q[1] <= cfg_sat;
        rcsn_pkg::REG_TRIM_YAW:      trim_q[2] <= cfg_sat;
        rcsn_pkg::REG_TRIM_THROTTLE: trim_q[3] <= cfg_sat;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its successor moves, so
  // bubbles collapse and, while a stage is empty, a stalled output lets frames enter
  // ---------------------------------------------------------------------------
  logic [NStages-1:0] vld_q, vld_d;
  logic [NStages:0]   en;

  assign en[NStages] = m_axis_tready_i;
  for (genvar s = NStages - 1; s >= 0; s--) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end

  always_comb begin
    for (int s = 0; s < NStages; s++) begin
      if (en[s]) begin
        vld_d[s] = (s == 0) ? s_axis_tvalid_i : vld_q[(s == 0) ? 0 : s - 1];
      end else begin
        vld_d[s] = vld_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NStages-1];

  // ---------------------------------------------------------------------------
  // stages 0-1: centering and the first constant division
  // ---------------------------------------------------------------------------
  logic [StickNumW-1:0] stk_num [NSticks];
  logic [StickNumW-1:0] stk_quo [NSticks];
  logic                 stk_neg [NSticks];
  logic                 stk_neg_q0 [NSticks];
  logic                 stk_neg_q1 [NSticks];

  for (genvar k = 0; k < NSticks; k++) begin : g_stick
    // mode sits after throttle in the frame
    localparam int Off = (k == NSticks - 1) ? NSticks * RawW : k * RawW;
    logic [RawW-1:0]        raw;
    logic signed [RawW+1:0] diff;
    logic [RawW-1:0]        mag;

    assign raw  = s_axis_tdata_i[Off +: RawW];
    assign diff = $signed({2'b00, raw}) - $signed((RawW + 2)'(RAW_CENTER));
    assign stk_neg[k] = diff[RawW+1];
    assign mag  = stk_neg[k] ? RawW'(-diff) : RawW'(diff);
    assign stk_num[k] = {mag, FracW'(0)} + StickNumW'(HalfStick);

    rcsn_cdiv #(
      .NUM_W (StickNumW),
      .DEN   (DenStick)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[1:0]),
      .num_i (stk_num[k]),
      .quo_o (stk_quo[k])
    );
  end

  logic [RawW-1:0]        thr_raw;
  logic signed [RawW+1:0] thr_diff;
  logic                   thr_pos;
  logic [StickNumW-1:0]   thr_num;
  logic [StickNumW-1:0]   thr_quo;
  logic                   thr_pos_q0, thr_pos_q1;

  // a raw throttle at or below RAW_MIN gives a zero magnitude before the trim
  assign thr_raw  = s_axis_tdata_i[(NSticks - 1) * RawW +: RawW];
  assign thr_diff = $signed({2'b00, thr_raw}) - $signed((RawW + 2)'(RAW_MIN));
  assign thr_pos  = (thr_diff > 0);
  assign thr_num  = thr_pos ? ({thr_diff[RawW-1:0], FracW'(0)} + StickNumW'(HalfThr))
                            : '0;

  rcsn_cdiv #(
    .NUM_W (StickNumW),
    .DEN   (DenThr)
  ) u_thr_div (
    .clk_i (clk_i),
    .en_i  (en[1:0]),
    .num_i (thr_num),
    .quo_o (thr_quo)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      stk_neg_q0 <= stk_neg;
      thr_pos_q0 <= thr_pos;
    end
    if (en[1]) begin
      stk_neg_q1 <= stk_neg_q0;
      thr_pos_q1 <= thr_pos_q0;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: clamp to +/-1.0, apply sign and trims
  // ---------------------------------------------------------------------------
  logic [ThrW-1:0]        stk_mag [NSticks];
  logic signed [SumW-1:0] stk_sv  [NSticks];
  logic signed [SumW-1:0] cmd_sum [NTrimmed];
  logic [ThrW-1:0]        thr_mag;
  logic signed [SumW-1:0] thr_sum;
  logic [ThrW-1:0]        thr_cl;

  always_comb begin
    for (int k = 0; k < NSticks; k++) begin
      stk_mag[k] = (stk_quo[k] > StickNumW'(rcsn_pkg::Q_ONE)) ? QOneU
                                                               : stk_quo[k][ThrW-1:0];
      stk_sv[k]  = stk_neg_q1[k] ? -$signed({2'b00, stk_mag[k]})
                                 : $signed({2'b00, stk_mag[k]});
    end
    for (int k = 0; k < NTrimmed; k++) begin
      cmd_sum[k] = stk_sv[k] + SumW'(trim_q[k]);
    end
    thr_mag = (thr_quo > StickNumW'(rcsn_pkg::Q_ONE)) ? QOneU : thr_quo[ThrW-1:0];
    if (!thr_pos_q1) begin
      thr_mag = '0;
    end
    thr_sum = $signed({2'b00, thr_mag}) + SumW'(trim_q[3]);
    if (thr_sum < 0) begin
      thr_cl = '0;
    end else if (thr_sum > QOneS) begin
      thr_cl = QOneU;
    end else begin
      thr_cl = thr_sum[ThrW-1:0];
    end
  end

  logic signed [SumW-1:0] cmd_q2 [NTrimmed];
  logic [ThrW-1:0]        thr_q2, thr_q3, thr_q4;
  logic [CmdW-1:0]        mode_q2, mode_q3, mode_q4;
  logic                   stab_q2, stab_q3, stab_q4;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cmd_q2  <= cmd_sum;
      thr_q2  <= thr_cl;
      mode_q2 <= CmdW'(stk_sv[NSticks-1]);
      stab_q2 <= !stk_neg_q1[NSticks-1] && (stk_mag[NSticks-1] != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stages 3-4: deadband and rescale through the second constant division
  // ---------------------------------------------------------------------------
  logic                db_neg  [NTrimmed];
  logic                db_zero [NTrimmed];
  logic [DbNumW-1:0]   db_num  [NTrimmed];
  logic [DbNumW-1:0]   db_quo  [NTrimmed];
  logic                db_neg_q3 [NTrimmed];
  logic                db_neg_q4 [NTrimmed];
  logic                db_zero_q3 [NTrimmed];
  logic                db_zero_q4 [NTrimmed];

  for (genvar k = 0; k < NTrimmed; k++) begin : g_db
    logic [CmdW-1:0] mag;
    logic [CmdW-1:0] over;

    assign db_neg[k] = cmd_q2[k][SumW-1];
    assign mag       = db_neg[k] ? CmdW'(-cmd_q2[k]) : CmdW'(cmd_q2[k]);
    // a value right at the edge is still inside the deadband
    assign db_zero[k] = (mag <= DbVal);
    assign over      = mag - DbVal;
    assign db_num[k] = db_zero[k] ? '0
                     : ({over[rcsn_pkg::DB_MAG_W-1:0], FracW'(0)} + DbNumW'(HalfDb));

    rcsn_cdiv #(
      .NUM_W (DbNumW),
      .DEN   (DenDb)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[4:3]),
      .num_i (db_num[k]),
      .quo_o (db_quo[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      db_neg_q3  <= db_neg;
      db_zero_q3 <= db_zero;
      thr_q3     <= thr_q2;
      mode_q3    <= mode_q2;
      stab_q3    <= stab_q2;
    end
    if (en[4]) begin
      db_neg_q4  <= db_neg_q3;
      db_zero_q4 <= db_zero_q3;
      thr_q4     <= thr_q3;
      mode_q4    <= mode_q3;
      stab_q4    <= stab_q3;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: output register, held while the sink stalls
  // ---------------------------------------------------------------------------
  logic [CmdW-1:0] cmd_out [NTrimmed];
  logic [CmdW-1:0] cmd_q5  [NTrimmed];
  logic [ThrW-1:0] thr_q5;
  logic [CmdW-1:0] mode_q5;
  logic            stab_q5;

  always_comb begin
    for (int k = 0; k < NTrimmed; k++) begin
      if (db_zero_q4[k]) begin
        cmd_out[k] = '0;
      end else if (db_neg_q4[k]) begin
        cmd_out[k] = -db_quo[k][CmdW-1:0];
      end else begin
        cmd_out[k] = db_quo[k][CmdW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      cmd_q5  <= cmd_out;
      thr_q5  <= thr_q4;
      mode_q5 <= mode_q4;
      stab_q5 <= stab_q4;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[rcsn_pkg::OUT_ROLL_LSB  +: CmdW] = cmd_q5[0];
    m_axis_tdata_o[rcsn_pkg::OUT_PITCH_LSB +: CmdW] = cmd_q5[1];
    m_axis_tdata_o[rcsn_pkg::OUT_YAW_LSB   +: CmdW] = cmd_q5[2];
    m_axis_tdata_o[rcsn_pkg::OUT_THR_LSB   +: ThrW] = thr_q5;
    m_axis_tdata_o[rcsn_pkg::OUT_MODE_LSB  +: CmdW] = mode_q5;
    m_axis_tdata_o[rcsn_pkg::OUT_STAB_BIT]          = stab_q5;
  end

endmodule

/* sv/rcsn_checker.sv */
// rcsn_checker: port-level assertions for rc_stick_normalizer_unit, with its bind
// depends on rcsn_pkg

module rcsn_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [rcsn_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam logic signed [rcsn_pkg::CMD_W-1:0] ModeMax = rcsn_pkg::CMD_W'(rcsn_pkg::Q_ONE);
  localparam logic [rcsn_pkg::THR_W-1:0]        ThrMax  = rcsn_pkg::THR_W'(rcsn_pkg::Q_ONE);

  logic signed [rcsn_pkg::CMD_W-1:0] mode_f;
  logic [rcsn_pkg::THR_W-1:0]        thr_f;
  logic                              stab_f;

  assign mode_f = m_axis_tdata_o[rcsn_pkg::OUT_MODE_LSB +: rcsn_pkg::CMD_W];
  assign thr_f  = m_axis_tdata_o[rcsn_pkg::OUT_THR_LSB +: rcsn_pkg::THR_W];
  assign stab_f = m_axis_tdata_o[rcsn_pkg::OUT_STAB_BIT];

  // a stalled result frame stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output frame changed while stalled");

  // stabilized follows the sign of the mode command
  a_stab_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (stab_f == (mode_f > 0)))
    else $error("stabilized disagrees with mode command");

  // throttle never leaves 0..1.0
  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (thr_f <= ThrMax))
    else $error("throttle command above full scale");

  // mode is clamped to +/-1.0
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (mode_f <= ModeMax) && (mode_f >= -ModeMax))
    else $error("mode command out of range");

endmodule

bind rc_stick_normalizer_unit rcsn_checker u_rcsn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* tb/sv/rc_stick_normalizer_unit_test.sv */
// rc_stick_normalizer_unit_test: self-checking stream testbench for the stick normalizer
// depends on rcsn_pkg and rc_stick_normalizer_unit; predicts every command frame in place

`timescale 1ns / 1ps

module rc_stick_normalizer_unit_test;

  // block parameters, kept equal to the instance below
  localparam int RAW_CENTER   = 992;
  localparam int RAW_MIN      = 172;
  localparam int RAW_MAX      = 1811;
  localparam int DEADBAND_Q14 = 819;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 28;
  localparam int PHASE_FRAMES = 216;

  // input frame, roll in the lowest bits
  typedef struct packed {
    logic [rcsn_pkg::RAW_W-1:0] mode_raw_in;
    logic [rcsn_pkg::RAW_W-1:0] throttle_raw;
    logic [rcsn_pkg::RAW_W-1:0] yaw_raw;
    logic [rcsn_pkg::RAW_W-1:0] pitch_raw;
    logic [rcsn_pkg::RAW_W-1:0] roll_raw;
  } raw_frame_t;

  // command frame, roll in the lowest bits
  typedef struct packed {
    logic                       stabilized;
    logic [rcsn_pkg::CMD_W-1:0] mode_cmd;
    logic [rcsn_pkg::THR_W-1:0] throttle_cmd;
    logic [rcsn_pkg::CMD_W-1:0] yaw_cmd;
    logic [rcsn_pkg::CMD_W-1:0] pitch_cmd;
    logic [rcsn_pkg::CMD_W-1:0] roll_cmd;
  } cmd_frame_t;

  // predicts the command frames and holds those still owed by the block
  class stick_cmd_board;
    longint     trims[4];
    cmd_frame_t expected_cmds[$];
    int         errors;
    int         frames_noted;
    int         cmds_checked;

    function new();
      foreach (trims[i]) trims[i] = 0;
      errors       = 0;
      frames_noted = 0;
      cmds_checked = 0;
    endfunction

    function longint round_div(longint num, longint den);
      if (den < 1) den = 1;
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // stick and mode: centered, full scale at RAW_MAX
    function longint center_norm(logic [rcsn_pkg::RAW_W-1:0] raw);
      return clip(round_div((longint'(raw) - RAW_CENTER) * rcsn_pkg::Q_ONE,
                            RAW_MAX - RAW_CENTER),
                  -rcsn_pkg::Q_ONE, rcsn_pkg::Q_ONE);
    endfunction

    function longint throttle_norm(logic [rcsn_pkg::RAW_W-1:0] raw);
      return clip(round_div((longint'(raw) - RAW_MIN) * rcsn_pkg::Q_ONE, RAW_MAX - RAW_MIN),
                  0, rcsn_pkg::Q_ONE);
    endfunction

    // zero inside the band, edges included, rescale outside it
    function longint band_rescale(longint v);
      longint den;
      den = rcsn_pkg::Q_ONE - DEADBAND_Q14;
      if (v > DEADBAND_Q14) return round_div((v - DEADBAND_Q14) * rcsn_pkg::Q_ONE, den);
      if (v < -DEADBAND_Q14) return round_div((v + DEADBAND_Q14) * rcsn_pkg::Q_ONE, den);
      return 0;
    endfunction

    function void set_trim(rcsn_pkg::cfg_reg_e idx, logic [rcsn_pkg::TRIM_W-1:0] value);
      trims[idx] = clip(longint'($signed(value)), -rcsn_pkg::TRIM_LIMIT,
                        rcsn_pkg::TRIM_LIMIT);
    endfunction

    function cmd_frame_t predict_cmds(raw_frame_t f);
      cmd_frame_t c;
      longint     mode_q;
      mode_q         = center_norm(f.mode_raw_in);
      c.roll_cmd     = rcsn_pkg::CMD_W'(band_rescale(center_norm(f.roll_raw)
                                                     + trims[rcsn_pkg::REG_TRIM_ROLL]));
      c.pitch_cmd    = rcsn_pkg::CMD_W'(band_rescale(center_norm(f.pitch_raw)
                                                     + trims[rcsn_pkg::REG_TRIM_PITCH]));
      c.yaw_cmd      = rcsn_pkg::CMD_W'(band_rescale(center_norm(f.yaw_raw)
                                                     + trims[rcsn_pkg::REG_TRIM_YAW]));
      c.throttle_cmd = rcsn_pkg::THR_W'(clip(throttle_norm(f.throttle_raw)
                                             + trims[rcsn_pkg::REG_TRIM_THROTTLE],
                                             0, rcsn_pkg::Q_ONE));
      c.mode_cmd     = rcsn_pkg::CMD_W'(mode_q);
      c.stabilized   = (mode_q > 0);
      return c;
    endfunction

    function void note_frame(raw_frame_t f);
      expected_cmds.push_back(predict_cmds(f));
      frames_noted++;
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_cmds(cmd_frame_t got);
      cmd_frame_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: command frame with no raw frame outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_cmds.pop_front();
      cmds_checked++;
      check_field("roll_cmd", $signed(want.roll_cmd), $signed(got.roll_cmd));
      check_field("pitch_cmd", $signed(want.pitch_cmd), $signed(got.pitch_cmd));
      check_field("yaw_cmd", $signed(want.yaw_cmd), $signed(got.yaw_cmd));
      check_field("throttle_cmd", want.throttle_cmd, got.throttle_cmd);
      check_field("mode_cmd", $signed(want.mode_cmd), $signed(got.mode_cmd));
      check_field("stabilized", want.stabilized, got.stabilized);
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [rcsn_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [rcsn_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                             cfg_valid_i     = 1'b0;
  logic                             cfg_ready_o;
  logic [rcsn_pkg::CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [rcsn_pkg::TRIM_W-1:0]      cfg_data_i      = '0;

  // idling switches for the sender and the receiver
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  int unsigned    cycles = 0;
  int             settings_run = 0;
  stick_cmd_board board;

  rc_stick_normalizer_unit #(
    .RAW_CENTER  (RAW_CENTER),
    .RAW_MIN     (RAW_MIN),
    .RAW_MAX     (RAW_MAX),
    .DEADBAND_Q14(DEADBAND_Q14)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far above the slowest correct run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d frames outstanding", cycles,
               board.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls at random while rx_idle is set
  always @(posedge clk_i) begin
    m_axis_tready_i <= !(rx_idle && ($urandom_range(99) < IDLE_PCT));
  end

  // every output transfer is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_cmds(cmd_frame_t'(m_axis_tdata_o));
    end
  end

  function automatic raw_frame_t make_frame(int roll, int pitch, int yaw, int thr, int mode);
    raw_frame_t f;
    f.roll_raw     = rcsn_pkg::RAW_W'(roll);
    f.pitch_raw    = rcsn_pkg::RAW_W'(pitch);
    f.yaw_raw      = rcsn_pkg::RAW_W'(yaw);
    f.throttle_raw = rcsn_pkg::RAW_W'(thr);
    f.mode_raw_in  = rcsn_pkg::RAW_W'(mode);
    return f;
  endfunction

  // mostly nominal stick travel, some full range, some near center and edges
  function automatic logic [rcsn_pkg::RAW_W-1:0] pick_raw();
    int sel;
    int edges[7];
    edges = '{0, 2047, RAW_MIN - 1, RAW_MIN, RAW_MAX, RAW_MAX + 1, RAW_CENTER};
    sel = $urandom_range(99);
    if (sel < 60) return rcsn_pkg::RAW_W'($urandom_range(RAW_MAX, RAW_MIN));
    if (sel < 80) return rcsn_pkg::RAW_W'($urandom_range(2047, 0));
    if (sel < 92) return rcsn_pkg::RAW_W'(RAW_CENTER - 60 + $urandom_range(120));
    return rcsn_pkg::RAW_W'(edges[$urandom_range(6)]);
  endfunction

  function automatic raw_frame_t random_frame();
    raw_frame_t f;
    f.roll_raw     = pick_raw();
    f.pitch_raw    = pick_raw();
    f.yaw_raw      = pick_raw();
    f.throttle_raw = pick_raw();
    f.mode_raw_in  = pick_raw();
    return f;
  endfunction

  // one input transfer, optional idle cycles first; tvalid stays up afterwards
  task automatic send_frame(raw_frame_t f);
    while (tx_idle && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rcsn_pkg::IN_TDATA_W'(f);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_frame(f);
  endtask

  task automatic send_random(int n);
    repeat (n) send_frame(random_frame());
  endtask

  // lower tvalid and wait until every command frame is back, then let the pipe settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_trim(rcsn_pkg::cfg_reg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= rcsn_pkg::TRIM_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_trim(idx, rcsn_pkg::TRIM_W'(value));
  endtask

  // only called with the block drained
  task automatic set_trims(int roll, int pitch, int yaw, int thr);
    write_trim(rcsn_pkg::REG_TRIM_ROLL, roll);
    write_trim(rcsn_pkg::REG_TRIM_PITCH, pitch);
    write_trim(rcsn_pkg::REG_TRIM_YAW, yaw);
    write_trim(rcsn_pkg::REG_TRIM_THROTTLE, thr);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_run++;
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on reset trims: extremes, nominal ends, center, mode sign
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(2047, 2047, 2047, 2047, 2047));
    send_frame(make_frame(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN));
    send_frame(make_frame(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX));
    send_frame(make_frame(RAW_CENTER, RAW_CENTER, RAW_CENTER, RAW_CENTER, RAW_CENTER));
    send_frame(make_frame(RAW_MIN - 1, RAW_MAX + 1, RAW_CENTER, RAW_MIN - 1, RAW_CENTER - 1));
    send_frame(make_frame(RAW_MAX + 1, RAW_MIN - 1, 0, RAW_MAX + 1, RAW_CENTER + 1));
    send_frame(make_frame(1033, 951, 1032, 173, 1810));
    send_frame(make_frame(952, 1034, 950, 1810, 173));
    send_frame(make_frame('h555, 'h2aa, 'h555, 'h2aa, 'h555));
    send_frame(make_frame('h2aa, 'h555, 'h2aa, 'h555, 'h2aa));
    drain();

    // deadband edges: center sticks land exactly on +band, -band and just past it
    set_trims(DEADBAND_Q14, -DEADBAND_Q14, DEADBAND_Q14 + 1, -rcsn_pkg::TRIM_LIMIT);
    send_frame(make_frame(RAW_CENTER, RAW_CENTER, RAW_CENTER, RAW_MIN, RAW_CENTER));
    send_frame(make_frame(RAW_MAX, RAW_MIN, 2047, RAW_MAX, 0));
    send_frame(make_frame(RAW_CENTER + 1, RAW_CENTER - 1, RAW_CENTER - 1, 300, 2047));
    send_frame(make_frame(0, 2047, RAW_MIN, RAW_MIN + 400, RAW_CENTER + 1));
    send_random(8);
    drain();

    // raw write values beyond the limit saturate to +/-0.2
    set_trims(4095, 4095, 4095, 4095);
    send_frame(make_frame(2047, 2047, 2047, 2047, 2047));
    send_frame(make_frame(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX - 200, RAW_MAX));
    send_random(PHASE_FRAMES);
    drain();

    set_trims(-4096, -4096, -4096, -4096);
    send_frame(make_frame(0, 0, 0, 0, 0));
    send_frame(make_frame(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN + 200, RAW_MIN));
    send_random(PHASE_FRAMES);
    drain();

    set_trims(rcsn_pkg::TRIM_LIMIT, -rcsn_pkg::TRIM_LIMIT, rcsn_pkg::TRIM_LIMIT + 1,
              -rcsn_pkg::TRIM_LIMIT - 1);
    send_random(PHASE_FRAMES);
    drain();

    // back to zero trims, with both sides running flat out
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_trims(0, 0, 0, 0);
    send_random(PHASE_FRAMES);
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    set_trims($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
              $urandom_range(8191));
    send_random(PHASE_FRAMES);
    drain();

    set_trims($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
              $urandom_range(8191));
    send_random(PHASE_FRAMES);
    drain();

    $display("sent %0d raw frames under %0d trim settings, %0d command frames checked",
             board.frames_noted, settings_run, board.cmds_checked);
    $display("stimulus spanned raw extremes, deadband edges, saturated trims and stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
